### rtl/core/dns_rsp_pkg.sv
package dns_rsp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_Q_NAME  = 4'd1,
        PH_Q_LABEL = 4'd2,
        PH_Q_FIXED = 4'd3,
        PH_A_NAME  = 4'd4,
        PH_A_LABEL = 4'd5,
        PH_A_PTR   = 4'd6,
        PH_A_FIXED = 4'd7,
        PH_A_ADDR  = 4'd8,
        PH_A_RDATA = 4'd9,
        PH_DONE    = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_ID   = 3'd2,
        ST_NOT_RESP = 3'd3,
        ST_NO_ANS   = 3'd4,
        ST_NO_A     = 3'd5
    } t_status;

    localparam logic [15:0] EXPECTED_ID_RESET = 16'h1234;
    localparam logic [15:0] RESP_FLAG_MASK    = 16'h8000;
    localparam logic [1:0]  PTR_TAG           = 2'b11;
    localparam logic [15:0] Q_FIXED_LEN       = 16'd4;
    localparam logic [15:0] Q_PTR_FIXED_LEN   = 16'd5;
    localparam logic [15:0] A_FIXED_LEN       = 16'd10;
    localparam logic [15:0] A_ADDR_LEN        = 16'd4;
    localparam logic [15:0] RTYPE_A           = 16'd1;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] address;
    } t_out_beat;

endpackage

### rtl/core/dns_rsp_core.sv
module dns_rsp_core #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  dns_rsp_pkg::t_in_beat i_beat,
    input  logic [15:0]          i_expected_id,
    output dns_rsp_pkg::t_out_beat o_result
);
    import dns_rsp_pkg::*;

    localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);

    logic [PosW-1:0] r_pos, n_pos;
    t_phase          r_phase, p_phase, n_phase;
    t_status         r_verdict, p_verdict, n_verdict;
    logic [15:0]     r_hdr, n_hdr;
    logic [15:0]     r_qleft, n_qleft;
    logic [15:0]     r_aleft, n_aleft;
    logic [15:0]     r_skip, n_skip;
    logic [15:0]     r_type, n_type;
    logic [15:0]     r_len, n_len;
    logic [31:0]     r_addr, n_addr;

    logic [7:0]  b;
    logic        parse_en;
    logic [15:0] word;
    logic [15:0] skip_dec;
    logic        skip_end;
    logic [15:0] fix_idx;
    logic [15:0] fix_type;
    logic [15:0] fix_len;
    logic [15:0] q_dec;
    logic [15:0] a_dec;
    logic        is_ptr;

    assign b        = i_beat.payload_byte;
    assign parse_en = i_take && (r_pos < PosMax);
    assign word     = {r_hdr[7:0], b};
    assign skip_dec = r_skip - 16'd1;
    assign skip_end = (skip_dec == 16'd0);
    assign fix_idx  = A_FIXED_LEN - r_skip;
    assign fix_type = (fix_idx <= 16'd1) ? {r_type[7:0], b} : r_type;
    assign fix_len  = (fix_idx >= 16'd8) ? {r_len[7:0], b} : r_len;
    assign q_dec    = r_qleft - 16'd1;
    assign a_dec    = r_aleft - 16'd1;
    assign is_ptr   = (b[7:6] == PTR_TAG);

    // Phase after this byte is parsed.
    always_comb begin
        p_phase = r_phase;
        if (parse_en) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == PosW'(11)) begin
                        if (r_verdict != ST_NO_A) begin
                            p_phase = PH_DONE;
                        end else if (r_qleft == 16'd0) begin
                            p_phase = PH_A_NAME;
                        end else begin
                            p_phase = PH_Q_NAME;
                        end
                    end
                end
                PH_Q_NAME: begin
                    if (b == 8'd0 || is_ptr) begin
                        p_phase = PH_Q_FIXED;
                    end else begin
                        p_phase = PH_Q_LABEL;
                    end
                end
                PH_Q_LABEL: begin
                    if (skip_end) p_phase = PH_Q_NAME;
                end
                PH_Q_FIXED: begin
                    if (skip_end) p_phase = (q_dec == 16'd0) ? PH_A_NAME : PH_Q_NAME;
                end
                PH_A_NAME: begin
                    if (b == 8'd0) begin
                        p_phase = PH_A_FIXED;
                    end else if (is_ptr) begin
                        p_phase = PH_A_PTR;
                    end else begin
                        p_phase = PH_A_LABEL;
                    end
                end
                PH_A_LABEL: begin
                    if (skip_end) p_phase = PH_A_NAME;
                end
                PH_A_PTR: begin
                    p_phase = PH_A_FIXED;
                end
                PH_A_FIXED: begin
                    if (skip_end) begin
                        if (fix_type == RTYPE_A && fix_len == A_ADDR_LEN) begin
                            p_phase = PH_A_ADDR;
                        end else if (fix_len == 16'd0) begin
                            p_phase = (a_dec == 16'd0) ? PH_DONE : PH_A_NAME;
                        end else begin
                            p_phase = PH_A_RDATA;
                        end
                    end
                end
                PH_A_ADDR: begin
                    if (skip_end) p_phase = PH_DONE;
                end
                PH_A_RDATA: begin
                    if (skip_end) p_phase = (a_dec == 16'd0) ? PH_DONE : PH_A_NAME;
                end
                default: begin
                    p_phase = r_phase;
                end
            endcase
        end
        n_phase = (i_take && i_beat.last_byte) ? PH_HEADER : p_phase;
    end

    // Counters, header fields, record fields and verdict.
    always_comb begin
        n_hdr     = r_hdr;
        n_qleft   = r_qleft;
        n_aleft   = r_aleft;
        n_skip    = r_skip;
        n_type    = r_type;
        n_len     = r_len;
        n_addr    = r_addr;
        p_verdict = r_verdict;
        n_pos     = r_pos;
        if (parse_en) begin
            n_pos = r_pos + PosW'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (!r_pos[0]) begin
                        n_hdr = {8'd0, b};
                    end else if (r_pos == PosW'(1)) begin
                        if (word != i_expected_id) p_verdict = ST_BAD_ID;
                    end else if (r_pos == PosW'(3)) begin
                        if (r_verdict == ST_NO_A && (word & RESP_FLAG_MASK) == 16'd0) begin
                            p_verdict = ST_NOT_RESP;
                        end
                    end else if (r_pos == PosW'(5)) begin
                        n_qleft = word;
                    end else if (r_pos == PosW'(7)) begin
                        n_aleft = word;
                        if (r_verdict == ST_NO_A && word == 16'd0) p_verdict = ST_NO_ANS;
                    end
                end
                PH_Q_NAME: begin
                    if (b == 8'd0) begin
                        n_skip = Q_FIXED_LEN;
                    end else if (is_ptr) begin
                        n_skip = Q_PTR_FIXED_LEN;
                    end else begin
                        n_skip = {8'd0, b};
                    end
                end
                PH_Q_LABEL: begin
                    n_skip = skip_dec;
                end
                PH_Q_FIXED: begin
                    n_skip = skip_dec;
                    if (skip_end) n_qleft = q_dec;
                end
                PH_A_NAME: begin
                    if (b == 8'd0) begin
                        n_skip = A_FIXED_LEN;
                    end else if (!is_ptr) begin
                        n_skip = {8'd0, b};
                    end
                end
                PH_A_LABEL: begin
                    n_skip = skip_dec;
                end
                PH_A_PTR: begin
                    n_skip = A_FIXED_LEN;
                end
                PH_A_FIXED: begin
                    n_type = fix_type;
                    n_len  = fix_len;
                    n_skip = skip_dec;
                    if (skip_end) begin
                        if (fix_type == RTYPE_A && fix_len == A_ADDR_LEN) begin
                            n_skip = A_ADDR_LEN;
                            n_addr = 32'd0;
                        end else if (fix_len == 16'd0) begin
                            n_aleft = a_dec;
                        end else begin
                            n_skip = fix_len;
                        end
                    end
                end
                PH_A_ADDR: begin
                    n_addr = {r_addr[23:0], b};
                    n_skip = skip_dec;
                    if (skip_end) p_verdict = ST_FOUND;
                end
                PH_A_RDATA: begin
                    n_skip = skip_dec;
                    if (skip_end) n_aleft = a_dec;
                end
                default: begin
                    n_skip = r_skip;
                end
            endcase
        end
        n_verdict = p_verdict;
        if (i_take && i_beat.last_byte) begin
            n_verdict = ST_NO_A;
            n_pos     = '0;
        end
    end

    // The result reflects the state after the marked byte has been parsed.
    always_comb begin
        o_result.status  = (p_phase == PH_HEADER) ? ST_SHORT : p_verdict;
        o_result.address = (o_result.status == ST_FOUND) ? n_addr : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= PH_HEADER;
            r_verdict <= ST_NO_A;
        end else begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_verdict <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr   <= n_hdr;
        r_qleft <= n_qleft;
        r_aleft <= n_aleft;
        r_skip  <= n_skip;
        r_type  <= n_type;
        r_len   <= n_len;
        r_addr  <= n_addr;
    end

endmodule

### rtl/core/dns_response_a_record_parser.sv
// Channel  Direction  Payload            Handshake
// in       input      t_in_beat          i_in_valid / o_in_ready
// out      output     t_out_beat         o_out_valid / i_out_ready
// cfg      input      expected ID [15:0] i_cfg_valid / o_cfg_ready
//
// One payload byte is taken per cycle unless a marked byte is stalled; a beat is held in the input
// register and is parsed as it leaves it, and its result is then held in the result register.
// Only the result register can stall the input: a marked byte waits while a result
// is still untaken. Synchronous active-low reset clears the parser to the header phase
// and the expected ID to 0x1234. Configuration writes are taken every cycle.
module dns_response_a_record_parser #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  dns_rsp_pkg::t_in_beat  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output dns_rsp_pkg::t_out_beat o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [15:0]            i_cfg_expected_id
);
    import dns_rsp_pkg::*;

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic [15:0] r_expected_id;
    logic      take;
    t_out_beat result;

    // A non-final beat never produces a result, so only a marked beat waits.
    assign take        = r_in_valid && (!r_in_beat.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || take;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

    dns_rsp_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_beat        (r_in_beat),
        .i_expected_id (r_expected_id),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_expected_id <= EXPECTED_ID_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take && r_in_beat.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_expected_id <= i_cfg_expected_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_data;
        end
        if (take && r_in_beat.last_byte) begin
            r_out_beat <= result;
        end
    end

endmodule
